>>> rtl/blit_pkg.sv
// Package for the 8-bit-per-pixel fill/copy blitter.
// Holds the transaction structs, register and opcode codes, and address helpers.
// No dependencies.
package blit_pkg;

    localparam int ADDR_BITS   = 32;
    localparam int OFFSET_BITS = 32;
    localparam int DIM_BITS    = 10;

    localparam int OPC_LSB     = 2;
    localparam int MIRROR_POS  = 6;
    localparam int KEY_EN_POS  = 8;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [DIM_BITS-1:0]  t_dim;

    typedef enum logic [2:0] {
        CFG_CONTROL  = 3'd0,
        CFG_COLOR    = 3'd1,
        CFG_SIZE     = 3'd2,
        CFG_GAP      = 3'd3,
        CFG_SRC      = 3'd4,
        CFG_DST      = 3'd5,
        CFG_SRC_WIN  = 3'd6,
        CFG_DST_WIN  = 3'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        OPC_COPY    = 3'd4,
        OPC_COPY_HP = 3'd5,
        OPC_FILL    = 3'd6,
        OPC_FILL_HP = 3'd7
    } t_opcode;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] source_byte;
    } t_in_item;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] write_offset;
        logic [7:0]             write_byte;
        logic                   write_enable;
        logic [OFFSET_BITS-1:0] fetch_offset;
        logic                   fetch_valid;
        logic                   last;
    } t_out_item;

    function automatic t_addr ext16(input logic [15:0] v);
        t_addr r;
        r = '0;
        r[15:0] = v;
        return r;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] to_offset(input t_addr a);
        logic [OFFSET_BITS-1:0] r;
        r = '0;
        r[ADDR_BITS-1:0] = a;
        return r;
    endfunction

    function automatic t_addr row_pitch(input logic [15:0] gap, input logic [1:0] lane,
                                        input t_dim width);
        logic [DIM_BITS:0] sum;
        logic [15:0]       span;
        sum  = {1'b0, width} + {{(DIM_BITS-1){1'b0}}, lane} + (DIM_BITS+1)'(3);
        span = 16'(sum[DIM_BITS:2]);
        return (ext16(gap) + ext16(span) - ext16(16'd1)) << 2;
    endfunction

endpackage

>>> rtl/blitter_fill_copy_pixel_engine.sv
// Top level of the 8-bit-per-pixel fill/copy blitter with color key and mirror.
// Uses blit_pkg for transaction structs, codes and address helpers.
//
//  Channel | Direction | Handshake                   | Payload
//  --------+-----------+-----------------------------+-------------------------
//  cfg     | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid  / o_in_ready    | i_in_item  (t_in_item)
//  out     | out       | o_out_valid / i_out_ready   | o_out_item (t_out_item)
//
// One input transaction per cycle while o_in_ready is high; a result, if any, is
// registered at acceptance and shown from the output register in the cycle after.
// The walk counters and row addresses update in the cycle of acceptance.
// A held result blocks input only while i_out_ready is low.
// Reset clears the config registers, the walk and the output valid, not the output item; cfg is always ready.
module blitter_fill_copy_pixel_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  blit_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output blit_pkg::t_out_item  o_out_item
);

    logic [31:0] r_ctrl, r_color, r_size, r_gap, r_src, r_dst, r_src_win, r_dst_win;

    blit_pkg::t_dim  r_row, r_col, n_row, n_col;
    blit_pkg::t_addr r_dst_row, r_src_row, n_dst_row, n_src_row;
    logic            r_running, n_running;

    logic                r_out_valid;
    blit_pkg::t_out_item r_out;

    logic [2:0]          w_opc;
    logic                w_fill, w_copy, w_mirror, w_key_en;
    blit_pkg::t_dim      w_width, w_height;
    logic [31:0]         w_src_diff, w_dst_diff;
    logic                w_col_end, w_row_end;
    logic                w_in_acc, w_emit, w_update;
    blit_pkg::t_dim      w_fetch_col;
    blit_pkg::t_addr     w_fetch_addr;
    blit_pkg::t_out_item w_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_in_acc    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl     <= '0;
            r_color    <= '0;
            r_size     <= '0;
            r_gap      <= '0;
            r_src      <= '0;
            r_dst      <= '0;
            r_src_win  <= '0;
            r_dst_win  <= '0;
        end else if (i_cfg_valid) begin
            unique case (blit_pkg::t_cfg_reg'(i_cfg_index))
                blit_pkg::CFG_CONTROL:  r_ctrl     <= i_cfg_data;
                blit_pkg::CFG_COLOR:    r_color    <= i_cfg_data;
                blit_pkg::CFG_SIZE:     r_size     <= i_cfg_data;
                blit_pkg::CFG_GAP:      r_gap      <= i_cfg_data;
                blit_pkg::CFG_SRC:      r_src      <= i_cfg_data;
                blit_pkg::CFG_DST:      r_dst      <= i_cfg_data;
                blit_pkg::CFG_SRC_WIN:  r_src_win  <= i_cfg_data;
                blit_pkg::CFG_DST_WIN:  r_dst_win  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_opc      = r_ctrl[blit_pkg::OPC_LSB +: 3];
    assign w_mirror   = r_ctrl[blit_pkg::MIRROR_POS];
    assign w_key_en   = r_ctrl[blit_pkg::KEY_EN_POS];
    assign w_width    = r_size[blit_pkg::DIM_BITS-1:0];
    assign w_height   = r_size[16 +: blit_pkg::DIM_BITS];
    assign w_src_diff = r_src - r_src_win;
    assign w_dst_diff = r_dst - r_dst_win;
    assign w_col_end  = ({1'b0, r_col} + (blit_pkg::DIM_BITS+1)'(1)) >= {1'b0, w_width};
    assign w_row_end  = ({1'b0, r_row} + (blit_pkg::DIM_BITS+1)'(1)) >= {1'b0, w_height};

    always_comb begin
        unique case (w_opc) inside
            blit_pkg::OPC_COPY, blit_pkg::OPC_COPY_HP: begin
                w_copy = 1'b1;
                w_fill = 1'b0;
            end
            blit_pkg::OPC_FILL, blit_pkg::OPC_FILL_HP: begin
                w_copy = 1'b0;
                w_fill = 1'b1;
            end
            default: begin
                w_copy = 1'b0;
                w_fill = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_row       = r_row;
        n_col       = r_col;
        n_dst_row   = r_dst_row;
        n_src_row   = r_src_row;
        n_running   = r_running;
        w_res       = '0;
        w_emit      = 1'b0;
        w_fetch_col = '0;
        if (w_copy || w_fill) begin
            if (i_in_item.action == blit_pkg::ACT_START) begin
                w_emit    = 1'b1;
                n_row     = '0;
                n_col     = '0;
                n_dst_row = w_dst_diff[blit_pkg::ADDR_BITS-1:0];
                n_src_row = w_src_diff[blit_pkg::ADDR_BITS-1:0];
                if (w_width == '0 || w_height == '0) begin
                    n_running  = 1'b0;
                    w_res.last = 1'b1;
                end else begin
                    n_running         = 1'b1;
                    w_res.fetch_valid = w_copy;
                end
            end else if (r_running) begin
                w_emit             = 1'b1;
                w_res.write_offset = blit_pkg::to_offset(r_dst_row +
                                     blit_pkg::ext16(16'(r_col)));
                if (w_fill) begin
                    w_res.write_byte   = r_color[31:24];
                    w_res.write_enable = 1'b1;
                end else begin
                    w_res.write_byte   = i_in_item.source_byte;
                    w_res.write_enable = !(w_key_en &&
                                           i_in_item.source_byte == r_color[23:16]);
                end
                if (w_col_end && w_row_end) begin
                    n_running  = 1'b0;
                    w_res.last = 1'b1;
                end else begin
                    if (w_col_end) begin
                        n_col     = '0;
                        n_row     = r_row + blit_pkg::DIM_BITS'(1);
                        n_dst_row = r_dst_row + blit_pkg::row_pitch(r_gap[31:16],
                                                                    r_dst[1:0], w_width);
                        n_src_row = r_src_row + blit_pkg::row_pitch(r_gap[15:0],
                                                                    r_src[1:0], w_width);
                    end else begin
                        n_col = r_col + blit_pkg::DIM_BITS'(1);
                    end
                    w_res.fetch_valid = w_copy;
                end
            end
            w_fetch_col = n_col;
        end
        if (w_mirror) begin
            w_fetch_addr = n_src_row + blit_pkg::ext16(16'(w_width))
                         - blit_pkg::ext16(16'd1) - blit_pkg::ext16(16'(w_fetch_col));
        end else begin
            w_fetch_addr = n_src_row + blit_pkg::ext16(16'(w_fetch_col));
        end
        if (w_res.fetch_valid) begin
            w_res.fetch_offset = blit_pkg::to_offset(w_fetch_addr);
        end
    end

    assign w_update = w_in_acc && w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_dst_row <= '0;
            r_src_row <= '0;
            r_running <= 1'b0;
        end else if (w_update) begin
            r_row     <= n_row;
            r_col     <= n_col;
            r_dst_row <= n_dst_row;
            r_src_row <= n_src_row;
            r_running <= n_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= w_update;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_out <= w_res;
        end
    end

    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_update && w_res.last |=> !r_running)
        else $error("engine still running after a last result");

    a_last_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.last && r_out.fetch_valid))
        else $error("result announces a fetch on its last position");

    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (w_copy || w_fill) && i_in_item.action == blit_pkg::ACT_START
        && w_width != '0 && w_height != '0
        |=> r_running && r_row == '0 && r_col == '0 && r_out_valid)
        else $error("start did not reset the walk");

    a_idle_pixel_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !r_running && i_in_item.action == blit_pkg::ACT_PIXEL |=> !r_out_valid)
        else $error("pixel on an idle engine produced a result");

endmodule
